// File: rtl/spdr_pkg.sv
// Shared constants, widths and control types of the shift-tolerant pixel distance row block.
// Used by spdr_lane, spdr_merge and the top level. No dependencies.
package spdr_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int SUM_BITS    = 48;
	localparam int OUT_BITS    = 48;
	localparam int NUM_COMP    = 4;

	localparam int SHIFT_BITS  = 11;
	localparam int WEIGHT_BITS = 4;

	// |tst + shift - ref| fits in one bit over the wider of sample and shift magnitude
	localparam int ABS_W  = ((SAMPLE_BITS > SHIFT_BITS - 1) ? SAMPLE_BITS : SHIFT_BITS - 1) + 1;
	localparam int DIFF_W = ABS_W + 1;
	localparam int SQ_W   = 2 * ABS_W;
	localparam int WSQ_W  = SQ_W + WEIGHT_BITS;
	localparam int ERR_W  = WSQ_W + $clog2(NUM_COMP);

	// Configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_C0  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_C1  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_C2  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_C3  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_C0 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_C1 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_C2 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_C3 = 4'd7;
	localparam int CFG_DATA_W = SHIFT_BITS;

	typedef struct packed {
		logic valid;
		logic last_cand;
		logic last_row;
	} ctl_t;

endpackage

// File: rtl/spdr_lane.sv
// One component lane: shifted difference, absolute value, square and weighted square.
// Three pipeline stages; depends on spdr_pkg.
module spdr_lane
	import spdr_pkg::*;
(
	input  logic                          clk,
	input  logic                          adv,
	input  logic [SAMPLE_BITS-1:0]        tst,
	input  logic [SAMPLE_BITS-1:0]        refs,
	input  logic signed [SHIFT_BITS-1:0]  shift,
	input  logic [WEIGHT_BITS-1:0]        weight,
	output logic [SQ_W-1:0]               dist_s3,
	output logic [WSQ_W-1:0]              wsq_s3
);

	logic signed [DIFF_W-1:0] tst_shift;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_abs;
	logic [ABS_W-1:0]         abs_s1;
	logic [SQ_W-1:0]          sq_s2;

	always_comb begin
		tst_shift = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, tst})
			+ $signed({{(DIFF_W-SHIFT_BITS){shift[SHIFT_BITS-1]}}, shift});
		diff      = tst_shift - $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, refs});
		diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			abs_s1  <= diff_abs[ABS_W-1:0];
			sq_s2   <= SQ_W'(abs_s1 * abs_s1);
			dist_s3 <= sq_s2;
			wsq_s3  <= WSQ_W'(sq_s2 * weight);
		end
	end

endmodule

// File: rtl/spdr_merge.sv
// Merge stage: sums the lane errors, keeps the window's best distances, accumulates
// the row sums and holds the result register. Depends on spdr_pkg.
module spdr_merge
	import spdr_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  ctl_t                               ctl_s3,
	input  logic [NUM_COMP-1:0][SQ_W-1:0]      dist_s3,
	input  logic [NUM_COMP-1:0][WSQ_W-1:0]     wsq_s3,
	output logic                               adv,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [NUM_COMP-1:0][OUT_BITS-1:0]  out_dist
);

	ctl_t                           ctl_s4;
	ctl_t                           ctl_s5;
	logic [ERR_W-1:0]               err_s4;
	logic [NUM_COMP-1:0][SQ_W-1:0]  dist_s4;
	logic [NUM_COMP-1:0][SQ_W-1:0]  win_dist_s5;

	logic [ERR_W-1:0]               best_err_q;
	logic [NUM_COMP-1:0][SQ_W-1:0]  best_dist_q;
	logic                           win_start_q;
	logic [NUM_COMP-1:0][SUM_BITS-1:0] row_sum_q;
	logic                           out_valid_q;

	logic                           take;
	logic [NUM_COMP-1:0][SQ_W-1:0]  chosen;
	logic [NUM_COMP-1:0][SUM_BITS-1:0] row_next;
	logic                           emit;

	// hold everything only when a row result meets a full output register
	assign emit = ctl_s5.valid && ctl_s5.last_row;
	assign adv  = !(emit && out_valid_q && !out_ready);

	always_comb begin
		take = win_start_q || (err_s4 < best_err_q);
		for (int i = 0; i < NUM_COMP; i++) begin
			chosen[i]   = take ? dist_s4[i] : best_dist_q[i];
			row_next[i] = row_sum_q[i] + SUM_BITS'(win_dist_s5[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4      <= '0;
			ctl_s5      <= '0;
			win_start_q <= 1'b1;
			row_sum_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (adv) begin
				ctl_s4       <= ctl_s3;
				ctl_s5.valid <= ctl_s4.valid && ctl_s4.last_cand;
				ctl_s5.last_cand <= ctl_s4.last_cand;
				ctl_s5.last_row  <= ctl_s4.last_row;
				if (ctl_s4.valid)
					win_start_q <= ctl_s4.last_cand;
				if (ctl_s5.valid) begin
					if (ctl_s5.last_row) begin
						row_sum_q   <= '0;
						out_valid_q <= 1'b1;
					end else begin
						row_sum_q <= row_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s4  <= ERR_W'(wsq_s3[0]) + ERR_W'(wsq_s3[1])
				+ ERR_W'(wsq_s3[2]) + ERR_W'(wsq_s3[3]);
			dist_s4 <= dist_s3;
			win_dist_s5 <= chosen;
			if (ctl_s4.valid && !ctl_s4.last_cand && take) begin
				best_err_q  <= err_s4;
				best_dist_q <= dist_s4;
			end
			if (emit) begin
				for (int i = 0; i < NUM_COMP; i++)
					out_dist[i] <= OUT_BITS'(row_next[i]);
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/shift_tolerant_pixel_distance_row.sv
// Shift-tolerant pixel distance over one picture row: top level with configuration
// registers and four component lanes. Depends on spdr_pkg, spdr_lane, spdr_merge.
//
// Usage:
//   Input channel (in_valid/in_ready): one candidate per transfer, pairing a test pixel
//   with one reference pixel of its search window; last_candidate closes the window,
//   last_in_row on that candidate closes the row.
//   Output channel (out_valid/out_ready): one transfer per row carrying the four row
//   sums of best squared distances, including the row's last pixel.
//   Configuration channel (cfg_valid/cfg_ready): index 0..3 writes a colour shift,
//   4..7 a weight, higher indexes are ignored. cfg_ready is always high; write only
//   while no item is in flight.
// Timing:
//   One candidate per cycle sustained while in_ready is high. A row result reaches
//   the output register after its closing candidate, passing through difference,
//   square, weighting, error sum and best selection, row accumulation.
// Reset:
//   Shifts 0, weights 1,1,1,0, row sums cleared, a fresh window pending, no result held.
// Stall:
//   While a result waits in the output register, candidates keep flowing; the
//   pipeline holds (in_ready low) only when a second row result reaches it.
module shift_tolerant_pixel_distance_row
	import spdr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] tst_c0,
	input  logic [SAMPLE_BITS-1:0] tst_c1,
	input  logic [SAMPLE_BITS-1:0] tst_c2,
	input  logic [SAMPLE_BITS-1:0] tst_c3,
	input  logic [SAMPLE_BITS-1:0] ref_c0,
	input  logic [SAMPLE_BITS-1:0] ref_c1,
	input  logic [SAMPLE_BITS-1:0] ref_c2,
	input  logic [SAMPLE_BITS-1:0] ref_c3,
	input  logic                   last_candidate,
	input  logic                   last_in_row,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_BITS-1:0]    row_dist_c0,
	output logic [OUT_BITS-1:0]    row_dist_c1,
	output logic [OUT_BITS-1:0]    row_dist_c2,
	output logic [OUT_BITS-1:0]    row_dist_c3,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic signed [SHIFT_BITS-1:0] shift_q  [NUM_COMP];
	logic [WEIGHT_BITS-1:0]       weight_q [NUM_COMP];

	logic [NUM_COMP-1:0][SAMPLE_BITS-1:0] tst;
	logic [NUM_COMP-1:0][SAMPLE_BITS-1:0] refs;
	logic [NUM_COMP-1:0][SQ_W-1:0]        dist_s3;
	logic [NUM_COMP-1:0][WSQ_W-1:0]       wsq_s3;
	logic [NUM_COMP-1:0][OUT_BITS-1:0]    out_dist;

	ctl_t ctl_s1;
	ctl_t ctl_s2;
	ctl_t ctl_s3;
	logic adv;

	assign cfg_ready = 1'b1;
	assign in_ready  = adv;

	assign tst  = {tst_c3, tst_c2, tst_c1, tst_c0};
	assign refs = {ref_c3, ref_c2, ref_c1, ref_c0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COMP; i++)
				shift_q[i] <= '0;
			weight_q[0] <= WEIGHT_BITS'(1);
			weight_q[1] <= WEIGHT_BITS'(1);
			weight_q[2] <= WEIGHT_BITS'(1);
			weight_q[3] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHIFT_C0:  shift_q[0]  <= cfg_data[SHIFT_BITS-1:0];
				REG_SHIFT_C1:  shift_q[1]  <= cfg_data[SHIFT_BITS-1:0];
				REG_SHIFT_C2:  shift_q[2]  <= cfg_data[SHIFT_BITS-1:0];
				REG_SHIFT_C3:  shift_q[3]  <= cfg_data[SHIFT_BITS-1:0];
				REG_WEIGHT_C0: weight_q[0] <= cfg_data[WEIGHT_BITS-1:0];
				REG_WEIGHT_C1: weight_q[1] <= cfg_data[WEIGHT_BITS-1:0];
				REG_WEIGHT_C2: weight_q[2] <= cfg_data[WEIGHT_BITS-1:0];
				REG_WEIGHT_C3: weight_q[3] <= cfg_data[WEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// control flags travel alongside the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1.valid     <= in_valid;
			ctl_s1.last_cand <= last_candidate;
			ctl_s1.last_row  <= last_in_row;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
		spdr_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.tst     (tst[g]),
			.refs    (refs[g]),
			.shift   (shift_q[g]),
			.weight  (weight_q[g]),
			.dist_s3 (dist_s3[g]),
			.wsq_s3  (wsq_s3[g])
		);
	end

	spdr_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s3    (ctl_s3),
		.dist_s3   (dist_s3),
		.wsq_s3    (wsq_s3),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_dist  (out_dist)
	);

	assign row_dist_c0 = out_dist[0];
	assign row_dist_c1 = out_dist[1];
	assign row_dist_c2 = out_dist[2];
	assign row_dist_c3 = out_dist[3];

endmodule

// File: bench/shift_tolerant_pixel_distance_row_tb.sv
// Testbench for shift_tolerant_pixel_distance_row: directed and random candidate streams,
// checked against a bench-side predictor of the window search and the row sums.
// Depends on spdr_pkg and the top-level RTL only.
module shift_tolerant_pixel_distance_row_tb;
	import spdr_pkg::*;

	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd13;

	typedef struct packed {
		logic [NUM_COMP-1:0][SAMPLE_BITS-1:0] tst;
		logic [NUM_COMP-1:0][SAMPLE_BITS-1:0] rfp;
		logic                                 lcand;
		logic                                 lrow;
	} pix_item_t;

	typedef struct packed {
		logic [NUM_COMP-1:0][OUT_BITS-1:0] sums;
	} row_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SAMPLE_BITS-1:0] tst_c0 = '0, tst_c1 = '0, tst_c2 = '0, tst_c3 = '0;
	logic [SAMPLE_BITS-1:0] ref_c0 = '0, ref_c1 = '0, ref_c2 = '0, ref_c3 = '0;
	logic last_candidate = 1'b0;
	logic last_in_row = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [OUT_BITS-1:0] row_dist_c0, row_dist_c1, row_dist_c2, row_dist_c3;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	shift_tolerant_pixel_distance_row u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.tst_c0        (tst_c0),
		.tst_c1        (tst_c1),
		.tst_c2        (tst_c2),
		.tst_c3        (tst_c3),
		.ref_c0        (ref_c0),
		.ref_c1        (ref_c1),
		.ref_c2        (ref_c2),
		.ref_c3        (ref_c3),
		.last_candidate(last_candidate),
		.last_in_row   (last_in_row),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.row_dist_c0   (row_dist_c0),
		.row_dist_c1   (row_dist_c1),
		.row_dist_c2   (row_dist_c2),
		.row_dist_c3   (row_dist_c3),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bench copy of the configuration and the search state
	int                  shift_r [NUM_COMP] = '{0, 0, 0, 0};
	int                  weight_r [NUM_COMP] = '{1, 1, 1, 0};
	longint              best_err = 32'hFFFF_FFFF;
	longint              best_sq [NUM_COMP] = '{0, 0, 0, 0};
	bit                  win_open = 1'b1;
	logic [SUM_BITS-1:0] row_acc [NUM_COMP] = '{'0, '0, '0, '0};

	pix_item_t cand_q[$];
	row_res_t  row_sums_q[$];

	bit in_fire = 1'b0, out_fire = 1'b0, cfg_fire = 1'b0;
	int snd_gap_max = 12;
	int rcv_gap_max = 12;
	bit long_hold_req = 1'b0;
	int err_cnt = 0;

	function automatic bit predict_pixel(input pix_item_t it, output row_res_t res);
		longint sq [NUM_COMP];
		longint err, t, r, d;
		err = 0;
		res = '0;
		for (int c = 0; c < NUM_COMP; c++) begin
			t = it.tst[c];
			r = it.rfp[c];
			d = t + shift_r[c] - r;
			if (d < 0)
				d = -d;
			sq[c] = d * d;
			err += sq[c] * weight_r[c];
		end
		// first candidate always wins; later ones only on a strictly smaller error
		if (win_open || err < best_err) begin
			best_err = err;
			for (int c = 0; c < NUM_COMP; c++)
				best_sq[c] = sq[c];
		end
		win_open = 1'b0;
		if (!it.lcand)
			return 1'b0;
		for (int c = 0; c < NUM_COMP; c++) begin
			row_acc[c] = row_acc[c] + SUM_BITS'(best_sq[c]);
			best_sq[c] = 0;
		end
		best_err = 32'hFFFF_FFFF;
		win_open = 1'b1;
		if (!it.lrow)
			return 1'b0;
		for (int c = 0; c < NUM_COMP; c++) begin
			res.sums[c] = OUT_BITS'(row_acc[c]);
			row_acc[c] = '0;
		end
		return 1'b1;
	endfunction

	function automatic pix_item_t mk_item(input int t0, t1, t2, t3, r0, r1, r2, r3,
		input bit lc, lr);
		pix_item_t it;
		it.tst = {SAMPLE_BITS'(t3), SAMPLE_BITS'(t2), SAMPLE_BITS'(t1), SAMPLE_BITS'(t0)};
		it.rfp = {SAMPLE_BITS'(r3), SAMPLE_BITS'(r2), SAMPLE_BITS'(r1), SAMPLE_BITS'(r0)};
		it.lcand = lc;
		it.lrow = lr;
		return it;
	endfunction

	// Sender: hold the payload until transfer, then wait a drawn gap before the next item
	int snd_gap_left = 0;
	always @(negedge clk) begin
		pix_item_t cur;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (snd_gap_left > 0) begin
				snd_gap_left--;
				in_valid <= 1'b0;
			end else if (cand_q.size() > 0) begin
				cur = cand_q.pop_front();
				tst_c0 <= cur.tst[0];
				tst_c1 <= cur.tst[1];
				tst_c2 <= cur.tst[2];
				tst_c3 <= cur.tst[3];
				ref_c0 <= cur.rfp[0];
				ref_c1 <= cur.rfp[1];
				ref_c2 <= cur.rfp[2];
				ref_c3 <= cur.rfp[3];
				last_candidate <= cur.lcand;
				last_in_row <= cur.lrow;
				in_valid <= 1'b1;
				snd_gap_left = $urandom_range(snd_gap_max, 0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall a drawn number of cycles after each transfer; one long hold on request
	int rcv_stall_left = 0;
	bit long_hold_seen = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				rcv_stall_left = $urandom_range(rcv_gap_max, 0);
			if (long_hold_req && !long_hold_seen) begin
				long_hold_seen = 1'b1;
				rcv_stall_left = LONG_HOLD;
			end
			if (rcv_stall_left > 0) begin
				rcv_stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: check results, predict on input transfers, track register writes
	int idle_cnt = 0;
	always @(posedge clk) begin
		row_res_t want, got, res;
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.sums = {row_dist_c3, row_dist_c2, row_dist_c1, row_dist_c0};
				if (row_sums_q.size() == 0) begin
					$error("row result with no expectation pending");
					err_cnt++;
				end else begin
					want = row_sums_q.pop_front();
					for (int c = 0; c < NUM_COMP; c++)
						if (got.sums[c] !== want.sums[c]) begin
							$error("row_dist_c%0d: expected %0d, actual %0d", c,
								want.sums[c], got.sums[c]);
							err_cnt++;
						end
				end
			end
			if (in_valid && in_ready)
				if (predict_pixel({tst_c3, tst_c2, tst_c1, tst_c0, ref_c3, ref_c2, ref_c1,
					ref_c0, last_candidate, last_in_row}, res))
					row_sums_q.push_back(res);
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					REG_SHIFT_C0, REG_SHIFT_C1, REG_SHIFT_C2, REG_SHIFT_C3:
						shift_r[cfg_index[1:0]] = int'($signed(cfg_data));
					REG_WEIGHT_C0, REG_WEIGHT_C1, REG_WEIGHT_C2, REG_WEIGHT_C3:
						weight_r[cfg_index[1:0]] = int'(cfg_data[WEIGHT_BITS-1:0]);
					default: ;
				endcase
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(negedge clk); while (!cfg_fire);
	endtask

	// Wait until the sender is done, every row sum is back and the pipeline has emptied
	task automatic wait_idle();
		while (cand_q.size() != 0 || in_valid || row_sums_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] draw_shift();
		case ($urandom_range(3, 0))
			0: return CFG_DATA_W'(1023);
			1: return CFG_DATA_W'(-1023);
			default: return CFG_DATA_W'(int'($urandom_range(2046, 0)) - 1023);
		endcase
	endfunction

	task automatic queue_rows(input int n_items, input int max_win, input int max_px);
		pix_item_t it, prev;
		logic [NUM_COMP-1:0][SAMPLE_BITS-1:0] tpix;
		int done, px, nc, v;
		done = 0;
		prev = '0;
		while (done < n_items) begin
			px = $urandom_range(max_px, 1);
			for (int p = 0; p < px; p++) begin
				nc = $urandom_range(max_win, 1);
				for (int c = 0; c < NUM_COMP; c++)
					if ($urandom_range(4, 0) == 0)
						tpix[c] = $urandom_range(1, 0) ? 10'd1023 : 10'd0;
					else
						tpix[c] = SAMPLE_BITS'($urandom_range(1023, 0));
				for (int k = 0; k < nc; k++) begin
					// mostly one test pixel per window, now and then a stray one
					it.tst = ($urandom_range(19, 0) == 0)
						? (NUM_COMP * SAMPLE_BITS)'({$urandom, $urandom}) : tpix;
					if (k > 0 && $urandom_range(5, 0) == 0) begin
						it.rfp = prev.rfp;
					end else begin
						for (int c = 0; c < NUM_COMP; c++)
							case ($urandom_range(9, 0))
								0, 1: it.rfp[c] = SAMPLE_BITS'($urandom_range(1023, 0));
								2: it.rfp[c] = $urandom_range(1, 0) ? 10'd1023 : 10'd0;
								default: begin
									v = int'(tpix[c]) + int'($urandom_range(16, 0)) - 8;
									if (v < 0)
										v = 0;
									if (v > 1023)
										v = 1023;
									it.rfp[c] = SAMPLE_BITS'(v);
								end
							endcase
					end
					it.lcand = (k == nc - 1);
					it.lrow = (it.lcand && p == px - 1) ||
						(!it.lcand && $urandom_range(9, 0) == 0);
					cand_q.push_back(it);
					prev = it;
					done++;
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset configuration: empty row, full-scale row, ties and a stray row mark
		cand_q.push_back(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
		cand_q.push_back(mk_item(1023, 1023, 1023, 1023, 0, 0, 0, 0, 1, 1));
		cand_q.push_back(mk_item(100, 100, 100, 100, 103, 100, 100, 100, 0, 0));
		cand_q.push_back(mk_item(100, 100, 100, 100, 100, 103, 100, 100, 0, 1));
		cand_q.push_back(mk_item(100, 100, 100, 100, 100, 100, 100, 0, 0, 0));
		cand_q.push_back(mk_item(100, 100, 100, 100, 100, 100, 104, 100, 1, 0));
		cand_q.push_back(mk_item(0, 0, 0, 0, 1023, 1023, 1023, 1023, 0, 0));
		cand_q.push_back(mk_item(0, 0, 0, 0, 1023, 1023, 1023, 1022, 1, 1));
		wait_idle();

		// Extreme shifts push the shifted test value out of sample range in both directions
		write_reg(REG_SHIFT_C0, CFG_DATA_W'(1023));
		write_reg(REG_SHIFT_C1, CFG_DATA_W'(-1023));
		write_reg(REG_SHIFT_C2, CFG_DATA_W'(1023));
		write_reg(REG_SHIFT_C3, CFG_DATA_W'(-1023));
		write_reg(REG_WEIGHT_C0, CFG_DATA_W'(15));
		write_reg(REG_WEIGHT_C1, CFG_DATA_W'(0));
		write_reg(REG_WEIGHT_C2, CFG_DATA_W'(15));
		write_reg(REG_WEIGHT_C3, {7'h7F, 4'hF});
		write_reg(REG_UNUSED, CFG_DATA_W'(-1));
		cfg_valid = 1'b0;
		cand_q.push_back(mk_item(1023, 0, 1023, 0, 0, 1023, 0, 1023, 1, 1));
		cand_q.push_back(mk_item(0, 1023, 0, 1023, 1023, 0, 1023, 0, 0, 0));
		cand_q.push_back(mk_item(1023, 0, 1023, 0, 0, 1023, 0, 1023, 0, 0));
		cand_q.push_back(mk_item(0, 1023, 0, 1023, 1023, 0, 1023, 0, 1, 0));
		cand_q.push_back(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			for (int k = 0; k < NUM_COMP; k++)
				write_reg(CFG_IDX_W'(REG_SHIFT_C0 + k),
					(ph == 1) ? CFG_DATA_W'(-1023) : draw_shift());
			for (int k = 0; k < NUM_COMP; k++)
				case (ph)
					0: write_reg(CFG_IDX_W'(REG_WEIGHT_C0 + k),
						CFG_DATA_W'($urandom) & ~CFG_DATA_W'(15));
					1: write_reg(CFG_IDX_W'(REG_WEIGHT_C0 + k), CFG_DATA_W'(15));
					default: write_reg(CFG_IDX_W'(REG_WEIGHT_C0 + k), CFG_DATA_W'($urandom));
				endcase
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
			cfg_valid = 1'b0;
			snd_gap_max = (ph == 2 || ph == 3) ? 0 : 12;
			rcv_gap_max = (ph == 2) ? 0 : 12;
			if (ph == 3) begin
				// receiver holds off while one-candidate rows pile up behind it
				long_hold_req = 1'b1;
				queue_rows(60, 1, 1);
				queue_rows(80, 6, 4);
			end else begin
				queue_rows(145, 8, 5);
			end
			wait_idle();
		end

		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/spdr_pkg.sv
rtl/spdr_lane.sv
rtl/spdr_merge.sv
rtl/shift_tolerant_pixel_distance_row.sv
bench/shift_tolerant_pixel_distance_row_tb.sv
